// File: src/mpbm_pkg.sv
`default_nettype none
package mpbm_pkg;

   // Default sizes of the stores
   localparam int MAX_NODES_DEF    = 256;
   localparam int MAX_PATTERNS_DEF = 16;
   localparam int ALPHABET_DEF     = 256;

   // Result limit per scanned byte
   localparam int MAX_RESULTS = 16;

   // Command codes
   localparam logic [2:0] CMD_CLEAR = 3'd0;
   localparam logic [2:0] CMD_BYTE  = 3'd1;
   localparam logic [2:0] CMD_END   = 3'd2;
   localparam logic [2:0] CMD_BUILD = 3'd3;
   localparam logic [2:0] CMD_SCAN  = 3'd4;

   // Status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NODE_FULL = 2'd1;
   localparam logic [1:0] ST_PAT_FULL  = 2'd2;
   localparam logic [1:0] ST_NOT_BUILT = 2'd3;

   // One result word
   typedef struct packed {
      logic        kind;
      logic [1:0]  status;
      logic [3:0]  pattern_id;
      logic [31:0] match_start;
      logic        last;
   } rsp_word_type;

   // Sequencer states
   typedef enum logic [4:0] {
      S_SWEEP,
      S_IDLE,
      S_RESP,
      S_ADD_RD,
      S_ADD_DEC,
      S_END_RD,
      S_END_DEC,
      S_END_WALK,
      S_B_ROOT_RD,
      S_B_ROOT_DEC,
      S_B_POP,
      S_B_POPW,
      S_B_FAILW,
      S_B_RA,
      S_B_RB,
      S_B_DEC,
      S_SC_RD,
      S_SC_DEC,
      S_NFP_RD,
      S_NFP_DEC,
      S_EMIT,
      S_FAIL_RD,
      S_FAIL_DEC,
      S_FLUSH
   } state_type;

endpackage
`default_nettype wire

// File: src/mpbm_ram.sv
`default_nettype none
module mpbm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire                                    clock,
   input  wire                                    we,
   input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire  [WIDTH-1:0]                       wdata,
   input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write one word, read one word registered
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

// File: src/mpbm_rsp_stage.sv
`default_nettype none
module mpbm_rsp_stage (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   load,
   input  mpbm_pkg::rsp_word_type word,
   output logic                  free,
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   output logic [39:0]           rsp_tdata,
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);

   logic                   valid_ff;
   mpbm_pkg::rsp_word_type word_ff;

   assign free = !valid_ff || rsp_tready;

   // Hold the word until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {2'b00, word_ff.match_start, word_ff.pattern_id, word_ff.status};
   assign rsp_tuser  = word_ff.kind;
   assign rsp_tlast  = word_ff.last;

endmodule
`default_nettype wire

// File: src/multi_pattern_byte_matcher.sv
`default_nettype none
// From acceptance to result load: an unknown command, a rejected byte or end, an unbuilt
// scan go straight to status; a byte on an existing edge reads its goto entry, one that
// adds a node also sweeps the new row, an end walks the ids at its node, clear sweeps the
// root row, and build scans the root row, then each node's failure link and row. The next
// request can be taken in the cycle after the load. A scan byte walks its failure chain and
// waits on output stalls. Reset is synchronous; then the root row is swept, req_tready low.
module multi_pattern_byte_matcher #(
   parameter int MAX_NODES    = mpbm_pkg::MAX_NODES_DEF,
   parameter int MAX_PATTERNS = mpbm_pkg::MAX_PATTERNS_DEF,
   parameter int ALPHABET     = mpbm_pkg::ALPHABET_DEF
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,   // data_byte[7:0], first_of_text[8], zero
   input  wire  [2:0]  req_tuser,   // cmd
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata,   // status[1:0], pattern_id[5:2], match_start[37:6], zero
   output logic        rsp_tuser,   // kind
   output logic        rsp_tlast    // last
);

   localparam int NODE_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int NT_W    = $clog2(MAX_NODES + 1);
   localparam int ENTRY_W = $clog2(2 * MAX_NODES);
   localparam int GDEPTH  = MAX_NODES * ALPHABET;
   localparam int GA_W    = $clog2(GDEPTH);
   localparam int CHR_W   = $clog2(ALPHABET);
   localparam int PID_W   = $clog2(MAX_PATTERNS + 1);
   localparam int PIDX_W  = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
   localparam logic [PID_W-1:0] NO_PAT = PID_W'(MAX_PATTERNS);

   // Reduce a byte into the alphabet by conditional subtraction
   function automatic logic [CHR_W-1:0] reduce_chr(input logic [7:0] b);
      logic [16:0] r;
      r = {9'd0, b};
      for (int k = 7; k >= 0; k--) begin
         if (r >= 17'(ALPHABET << k)) begin
            r = r - 17'(ALPHABET << k);
         end
      end
      return r[CHR_W-1:0];
   endfunction

   function automatic logic [NODE_W-1:0] tgt(input logic [ENTRY_W-1:0] e);
      logic [ENTRY_W-1:0] t;
      t = (e >= ENTRY_W'(MAX_NODES)) ? e - ENTRY_W'(MAX_NODES) : e;
      return t[NODE_W-1:0];
   endfunction

   function automatic logic [GA_W-1:0] gaddr(input logic [NODE_W-1:0] n,
                                             input logic [CHR_W-1:0] c);
      return GA_W'(n) * GA_W'(ALPHABET) + GA_W'(c);
   endfunction

   // Control and working registers
   mpbm_pkg::state_type state_ff, state_in;
   logic               resp_en_ff, resp_en_in;
   logic [NT_W-1:0]    node_total_ff, node_total_in;
   logic [PID_W-1:0]   pat_total_ff, pat_total_in;
   logic [NODE_W-1:0]  ins_node_ff, ins_node_in;
   logic [7:0]         ins_len_ff, ins_len_in;
   logic               broken_ff, broken_in;
   logic               built_ff, built_in;
   logic [NODE_W-1:0]  match_node_ff, match_node_in;
   logic [31:0]        text_pos_ff, text_pos_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [NODE_W-1:0]  row_ff, row_in;
   logic [CHR_W-1:0]   c_ff, c_in;
   logic [NT_W-1:0]    head_ff, head_in;
   logic [NT_W-1:0]    tail_ff, tail_in;

   logic [CHR_W-1:0]   chr_ff, chr_in;
   logic [1:0]         st_ff, st_in;
   logic [ENTRY_W-1:0] e_ff, e_in;
   logic [NODE_W-1:0]  u_ff, u_in;
   logic [NODE_W-1:0]  f_ff, f_in;
   logic [NODE_W-1:0]  n_ff, n_in;
   logic [PID_W-1:0]   p_ff, p_in;
   logic [4:0]         k_ff, k_in;
   logic [31:0]        pos_ff, pos_in;
   mpbm_pkg::rsp_word_type pend_ff, pend_in;

   // Small pattern stores
   logic [7:0]         plen_ff [MAX_PATTERNS];
   logic [PID_W-1:0]   pnext_ff [MAX_PATTERNS];
   logic               pat_we, next_we;
   logic [PIDX_W-1:0]  pat_widx, next_widx, pat_ridx;
   logic [PID_W-1:0]   next_wdata;

   // Memory ports
   logic               g_we;
   logic [GA_W-1:0]    g_waddr, g_raddr;
   logic [ENTRY_W-1:0] g_wdata, g_rdata;
   logic               f_we;
   logic [NODE_W-1:0]  f_waddr, f_raddr, f_wdata, f_rdata;
   logic               n_we;
   logic [NODE_W-1:0]  n_waddr, n_raddr;
   logic [PID_W-1:0]   n_wdata, n_rdata;
   logic               q_we;
   logic [NODE_W-1:0]  q_waddr, q_raddr, q_wdata, q_rdata;

   // Output stage
   logic                   out_load, out_free;
   mpbm_pkg::rsp_word_type out_word;

   logic               accept;
   logic [2:0]         in_cmd;
   logic [CHR_W-1:0]   in_chr;
   logic               in_first;
   logic [NODE_W-1:0]  v_node;
   logic [NODE_W-1:0]  fw_node;
   mpbm_pkg::rsp_word_type new_word;

   assign req_tready = (state_ff == mpbm_pkg::S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign in_cmd     = req_tuser;
   assign in_chr     = reduce_chr(req_tdata[7:0]);
   assign in_first   = req_tdata[8];
   assign pat_ridx   = p_ff[PIDX_W-1:0];

   mpbm_ram #(.WIDTH(ENTRY_W), .DEPTH(GDEPTH)) u_goto (
      .clock(clock), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
      .raddr(g_raddr), .rdata(g_rdata)
   );

   mpbm_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_fail (
      .clock(clock), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
      .raddr(f_raddr), .rdata(f_rdata)
   );

   mpbm_ram #(.WIDTH(PID_W), .DEPTH(MAX_NODES)) u_nfp (
      .clock(clock), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
      .raddr(n_raddr), .rdata(n_rdata)
   );

   mpbm_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue (
      .clock(clock), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
      .raddr(q_raddr), .rdata(q_rdata)
   );

   mpbm_rsp_stage u_rsp (
      .clock(clock), .reset(reset), .load(out_load), .word(out_word), .free(out_free),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   // Sequencer: next state, store accesses and result loads
   always_comb begin
      state_in      = state_ff;
      resp_en_in    = resp_en_ff;
      node_total_in = node_total_ff;
      pat_total_in  = pat_total_ff;
      ins_node_in   = ins_node_ff;
      ins_len_in    = ins_len_ff;
      broken_in     = broken_ff;
      built_in      = built_ff;
      match_node_in = match_node_ff;
      text_pos_in   = text_pos_ff;
      pend_valid_in = pend_valid_ff;
      row_in        = row_ff;
      c_in          = c_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      chr_in        = chr_ff;
      st_in         = st_ff;
      e_in          = e_ff;
      u_in          = u_ff;
      f_in          = f_ff;
      n_in          = n_ff;
      p_in          = p_ff;
      k_in          = k_ff;
      pos_in        = pos_ff;
      pend_in       = pend_ff;

      g_we = 1'b0; g_waddr = gaddr(row_ff, c_ff); g_wdata = '0; g_raddr = '0;
      f_we = 1'b0; f_waddr = row_ff; f_wdata = '0; f_raddr = n_ff;
      n_we = 1'b0; n_waddr = row_ff; n_wdata = NO_PAT; n_raddr = n_ff;
      q_we = 1'b0; q_waddr = tail_ff[NODE_W-1:0]; q_wdata = '0;
      q_raddr = head_ff[NODE_W-1:0];
      pat_we = 1'b0; pat_widx = pat_total_ff[PIDX_W-1:0];
      next_we = 1'b0; next_widx = pat_total_ff[PIDX_W-1:0]; next_wdata = NO_PAT;
      out_load = 1'b0;
      out_word = '0;

      v_node  = tgt(e_ff);
      fw_node = tgt(g_rdata);

      new_word.kind        = 1'b1;
      new_word.status      = mpbm_pkg::ST_OK;
      new_word.pattern_id  = 4'(p_ff);
      new_word.match_start = pos_ff - 32'(plen_ff[pat_ridx]) + 32'd1;
      new_word.last        = 1'b0;

      case (state_ff)
         // Zero one goto row and init the node
         mpbm_pkg::S_SWEEP: begin
            g_we = 1'b1;
            f_we = 1'b1;
            n_we = 1'b1;
            if (c_ff == CHR_W'(ALPHABET - 1)) begin
               state_in = resp_en_ff ? mpbm_pkg::S_RESP : mpbm_pkg::S_IDLE;
            end else begin
               c_in = c_ff + 1'b1;
            end
         end

         mpbm_pkg::S_IDLE: begin
            if (accept) begin
               chr_in     = in_chr;
               st_in      = mpbm_pkg::ST_OK;
               resp_en_in = 1'b1;
               state_in   = mpbm_pkg::S_RESP;
               case (in_cmd)
                  mpbm_pkg::CMD_CLEAR: begin
                     node_total_in = NT_W'(1);
                     pat_total_in  = '0;
                     ins_node_in   = '0;
                     ins_len_in    = '0;
                     broken_in     = 1'b0;
                     built_in      = 1'b0;
                     match_node_in = '0;
                     text_pos_in   = '0;
                     row_in        = '0;
                     c_in          = '0;
                     state_in      = mpbm_pkg::S_SWEEP;
                  end
                  mpbm_pkg::CMD_BYTE: begin
                     built_in = 1'b0;
                     if (broken_ff) begin
                        st_in = mpbm_pkg::ST_NODE_FULL;
                     end else begin
                        state_in = mpbm_pkg::S_ADD_RD;
                     end
                  end
                  mpbm_pkg::CMD_END: begin
                     built_in = 1'b0;
                     if (broken_ff || pat_total_ff >= PID_W'(MAX_PATTERNS)) begin
                        st_in       = broken_ff ? mpbm_pkg::ST_NODE_FULL
                                                : mpbm_pkg::ST_PAT_FULL;
                        ins_node_in = '0;
                        ins_len_in  = '0;
                        broken_in   = 1'b0;
                     end else begin
                        state_in = mpbm_pkg::S_END_RD;
                     end
                  end
                  mpbm_pkg::CMD_BUILD: begin
                     c_in     = '0;
                     head_in  = '0;
                     tail_in  = '0;
                     state_in = mpbm_pkg::S_B_ROOT_RD;
                  end
                  mpbm_pkg::CMD_SCAN: begin
                     if (!built_ff) begin
                        st_in = mpbm_pkg::ST_NOT_BUILT;
                     end else begin
                        n_in        = in_first ? '0 : match_node_ff;
                        pos_in      = in_first ? 32'd0 : text_pos_ff;
                        text_pos_in = (in_first ? 32'd0 : text_pos_ff) + 32'd1;
                        k_in        = '0;
                        state_in    = mpbm_pkg::S_SC_RD;
                     end
                  end
                  default: begin
                     st_in = mpbm_pkg::ST_OK;
                  end
               endcase
            end
         end

         // Send one status word
         mpbm_pkg::S_RESP: begin
            if (out_free) begin
               out_load        = 1'b1;
               out_word.status = st_ff;
               out_word.last   = 1'b1;
               state_in        = mpbm_pkg::S_IDLE;
            end
         end

         mpbm_pkg::S_ADD_RD: begin
            g_raddr  = gaddr(ins_node_ff, chr_ff);
            state_in = mpbm_pkg::S_ADD_DEC;
         end

         mpbm_pkg::S_ADD_DEC: begin
            state_in = mpbm_pkg::S_RESP;
            if (g_rdata >= ENTRY_W'(MAX_NODES)) begin
               ins_node_in = fw_node;
               ins_len_in  = (ins_len_ff != 8'd255) ? ins_len_ff + 8'd1 : ins_len_ff;
            end else if (node_total_ff >= NT_W'(MAX_NODES)) begin
               broken_in = 1'b1;
               st_in     = mpbm_pkg::ST_NODE_FULL;
            end else begin
               g_we          = 1'b1;
               g_waddr       = gaddr(ins_node_ff, chr_ff);
               g_wdata       = ENTRY_W'(MAX_NODES) + ENTRY_W'(node_total_ff);
               node_total_in = node_total_ff + 1'b1;
               ins_node_in   = node_total_ff[NODE_W-1:0];
               ins_len_in    = (ins_len_ff != 8'd255) ? ins_len_ff + 8'd1 : ins_len_ff;
               row_in        = node_total_ff[NODE_W-1:0];
               c_in          = '0;
               state_in      = mpbm_pkg::S_SWEEP;
            end
         end

         // Record the new pattern and read its node's list head
         mpbm_pkg::S_END_RD: begin
            pat_we   = 1'b1;
            next_we  = 1'b1;
            n_raddr  = ins_node_ff;
            state_in = mpbm_pkg::S_END_DEC;
         end

         mpbm_pkg::S_END_DEC: begin
            if (n_rdata >= NO_PAT) begin
               n_we         = 1'b1;
               n_waddr      = ins_node_ff;
               n_wdata      = pat_total_ff;
               pat_total_in = pat_total_ff + 1'b1;
               ins_node_in  = '0;
               ins_len_in   = '0;
               state_in     = mpbm_pkg::S_RESP;
            end else begin
               p_in     = n_rdata;
               state_in = mpbm_pkg::S_END_WALK;
            end
         end

         // Walk to the list tail and append
         mpbm_pkg::S_END_WALK: begin
            if (pnext_ff[pat_ridx] < NO_PAT) begin
               p_in = pnext_ff[pat_ridx];
            end else begin
               next_we      = 1'b1;
               next_widx    = pat_ridx;
               next_wdata   = pat_total_ff;
               pat_total_in = pat_total_ff + 1'b1;
               ins_node_in  = '0;
               ins_len_in   = '0;
               state_in     = mpbm_pkg::S_RESP;
            end
         end

         mpbm_pkg::S_B_ROOT_RD: begin
            g_raddr = GA_W'(c_ff);
            if (c_ff == '0) begin
               f_we    = 1'b1;
               f_waddr = '0;
            end
            state_in = mpbm_pkg::S_B_ROOT_DEC;
         end

         // Queue the root's children, fill the root's holes
         mpbm_pkg::S_B_ROOT_DEC: begin
            if (g_rdata >= ENTRY_W'(MAX_NODES)) begin
               f_we    = 1'b1;
               f_waddr = fw_node;
               if (tail_ff < NT_W'(MAX_NODES)) begin
                  q_we    = 1'b1;
                  q_wdata = fw_node;
                  tail_in = tail_ff + 1'b1;
               end
            end else begin
               g_we    = 1'b1;
               g_waddr = GA_W'(c_ff);
            end
            if (c_ff == CHR_W'(ALPHABET - 1)) begin
               state_in = mpbm_pkg::S_B_POP;
            end else begin
               c_in     = c_ff + 1'b1;
               state_in = mpbm_pkg::S_B_ROOT_RD;
            end
         end

         mpbm_pkg::S_B_POP: begin
            if (head_ff < tail_ff) begin
               state_in = mpbm_pkg::S_B_POPW;
            end else begin
               built_in = 1'b1;
               state_in = mpbm_pkg::S_RESP;
            end
         end

         mpbm_pkg::S_B_POPW: begin
            u_in     = q_rdata;
            f_raddr  = q_rdata;
            head_in  = head_ff + 1'b1;
            state_in = mpbm_pkg::S_B_FAILW;
         end

         mpbm_pkg::S_B_FAILW: begin
            f_in     = f_rdata;
            c_in     = '0;
            state_in = mpbm_pkg::S_B_RA;
         end

         mpbm_pkg::S_B_RA: begin
            g_raddr  = gaddr(u_ff, c_ff);
            state_in = mpbm_pkg::S_B_RB;
         end

         mpbm_pkg::S_B_RB: begin
            e_in     = g_rdata;
            g_raddr  = gaddr(f_ff, c_ff);
            state_in = mpbm_pkg::S_B_DEC;
         end

         // Link a child or fill a hole from the failure node's row
         mpbm_pkg::S_B_DEC: begin
            if (e_ff >= ENTRY_W'(MAX_NODES)) begin
               f_we    = 1'b1;
               f_waddr = v_node;
               f_wdata = fw_node;
               if (tail_ff < NT_W'(MAX_NODES)) begin
                  q_we    = 1'b1;
                  q_wdata = v_node;
                  tail_in = tail_ff + 1'b1;
               end
            end else begin
               g_we    = 1'b1;
               g_waddr = gaddr(u_ff, c_ff);
               g_wdata = ENTRY_W'(fw_node);
            end
            if (c_ff == CHR_W'(ALPHABET - 1)) begin
               state_in = mpbm_pkg::S_B_POP;
            end else begin
               c_in     = c_ff + 1'b1;
               state_in = mpbm_pkg::S_B_RA;
            end
         end

         mpbm_pkg::S_SC_RD: begin
            g_raddr  = gaddr(n_ff, chr_ff);
            state_in = mpbm_pkg::S_SC_DEC;
         end

         mpbm_pkg::S_SC_DEC: begin
            n_in          = fw_node;
            match_node_in = fw_node;
            state_in      = mpbm_pkg::S_NFP_RD;
         end

         mpbm_pkg::S_NFP_RD: begin
            state_in = mpbm_pkg::S_NFP_DEC;
         end

         mpbm_pkg::S_NFP_DEC: begin
            p_in     = n_rdata;
            state_in = mpbm_pkg::S_EMIT;
         end

         // Emit the node's ids; keep one back to mark the last
         mpbm_pkg::S_EMIT: begin
            if (p_ff < NO_PAT && k_ff < 5'(mpbm_pkg::MAX_RESULTS)) begin
               if (!pend_valid_ff || out_free) begin
                  if (pend_valid_ff) begin
                     out_load = 1'b1;
                     out_word = pend_ff;
                  end
                  pend_in       = new_word;
                  pend_valid_in = 1'b1;
                  k_in          = k_ff + 5'd1;
                  p_in          = pnext_ff[pat_ridx];
               end
            end else if (n_ff == '0 || k_ff >= 5'(mpbm_pkg::MAX_RESULTS)) begin
               state_in = mpbm_pkg::S_FLUSH;
            end else begin
               state_in = mpbm_pkg::S_FAIL_RD;
            end
         end

         mpbm_pkg::S_FAIL_RD: begin
            state_in = mpbm_pkg::S_FAIL_DEC;
         end

         mpbm_pkg::S_FAIL_DEC: begin
            n_in     = f_rdata;
            state_in = mpbm_pkg::S_NFP_RD;
         end

         // Send the held match as the last one
         mpbm_pkg::S_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = mpbm_pkg::S_IDLE;
            end else if (out_free) begin
               out_load      = 1'b1;
               out_word      = pend_ff;
               out_word.last = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = mpbm_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = mpbm_pkg::S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mpbm_pkg::S_SWEEP;
         resp_en_ff    <= 1'b0;
         node_total_ff <= NT_W'(1);
         pat_total_ff  <= '0;
         ins_node_ff   <= '0;
         ins_len_ff    <= '0;
         broken_ff     <= 1'b0;
         built_ff      <= 1'b0;
         match_node_ff <= '0;
         text_pos_ff   <= '0;
         pend_valid_ff <= 1'b0;
         row_ff        <= '0;
         c_ff          <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         resp_en_ff    <= resp_en_in;
         node_total_ff <= node_total_in;
         pat_total_ff  <= pat_total_in;
         ins_node_ff   <= ins_node_in;
         ins_len_ff    <= ins_len_in;
         broken_ff     <= broken_in;
         built_ff      <= built_in;
         match_node_ff <= match_node_in;
         text_pos_ff   <= text_pos_in;
         pend_valid_ff <= pend_valid_in;
         row_ff        <= row_in;
         c_ff          <= c_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      chr_ff  <= chr_in;
      st_ff   <= st_in;
      e_ff    <= e_in;
      u_ff    <= u_in;
      f_ff    <= f_in;
      n_ff    <= n_in;
      p_ff    <= p_in;
      k_ff    <= k_in;
      pos_ff  <= pos_in;
      pend_ff <= pend_in;
   end

   // Pattern length and same-node list
   always_ff @(posedge clock) begin
      if (pat_we) begin
         plen_ff[pat_widx] <= ins_len_ff;
      end
      if (next_we) begin
         pnext_ff[next_widx] <= next_wdata;
      end
   end

endmodule
`default_nettype wire
